/* rtl/rbf_kernel_regression_predict_defines.svh */
// ---------------------------------------------------------------------------
// rbf kernel regression predictor: assertion macros
// implication checks, same cycle and next cycle
// ---------------------------------------------------------------------------
`ifndef RBF_KERNEL_REGRESSION_PREDICT_DEFINES_SVH
`define RBF_KERNEL_REGRESSION_PREDICT_DEFINES_SVH
`ifndef SYNTHESIS
`define RKR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RKR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RKR_ASSERT_SAME(label, clk, rst, ante, cons)
`define RKR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/rkr_pkg.sv */
// ---------------------------------------------------------------------------
// rkr_pkg
// shared types, codes and the exponential table builder
// ---------------------------------------------------------------------------
`default_nettype none
package rkr_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [2:0] CSR_INV_SCALE_0 = 3'd0;
   localparam logic [2:0] CSR_INV_SCALE_1 = 3'd1;
   localparam logic [2:0] CSR_INV_SCALE_2 = 3'd2;
   localparam logic [2:0] CSR_INV_SCALE_3 = 3'd3;
   localparam logic [2:0] CSR_SIGNAL_VAR  = 3'd4;
   localparam logic [2:0] CSR_MEAN_OFFSET = 3'd5;
   localparam logic [2:0] CSR_TRAIN_COUNT = 3'd6;

   localparam int FEAT_W   = 16;
   localparam int WEIGHT_W = 24;
   localparam int Q_W      = 20;

   typedef struct packed {
      logic            far;
      logic [Q_W-1:0]  q;
   } lane_res_type;

   typedef struct packed {
      logic        busy;
      logic [63:0] acc;
   } merge_stat_type;

   function automatic logic [63:0] div_small(input logic [63:0] v, input int n);
      logic [63:0] r;
      case (n)
         2:       r = v / 2;
         3:       r = v / 3;
         4:       r = v / 4;
         5:       r = v / 5;
         6:       r = v / 6;
         7:       r = v / 7;
         8:       r = v / 8;
         9:       r = v / 9;
         10:      r = v / 10;
         11:      r = v / 11;
         12:      r = v / 12;
         13:      r = v / 13;
         14:      r = v / 14;
         15:      r = v / 15;
         default: r = v;
      endcase
      return r;
   endfunction

   // entry k of exp(-8k/depth), x is the Q.32 step argument
   function automatic logic [63:0] exp_entry(input int k, input logic [63:0] x);
      logic [63:0] t;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] step;
      logic [63:0] c;
      int          n;
      int          j;
      t   = 64'd1 << 32;
      pos = t;
      neg = 64'd0;
      for (n = 1; n <= 15; n++) begin
         t = div_small((t * x) >> 32, n);
         if (n % 2 == 1) neg = neg + t;
         else pos = pos + t;
      end
      step = pos - neg;
      c = 64'd1 << 32;
      for (j = 0; j < k; j++) begin
         c = (c * step) >> 32;
      end
      return (c + 64'h8000) >> 16;
   endfunction

endpackage
`default_nettype wire

/* rtl/rkr_ram.sv */
// ---------------------------------------------------------------------------
// rkr_ram
// single write port, single registered read port
// ---------------------------------------------------------------------------
`default_nettype none
module rkr_ram #(
   parameter int WIDTH = 88,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/rkr_lane.sv */
// ---------------------------------------------------------------------------
// rkr_lane
// one dimension: scaled distance and its square, two stages
// ---------------------------------------------------------------------------
`default_nettype none
module rkr_lane (
   input  wire logic                        clock,
   input  wire logic signed [15:0]          query_feat,
   input  wire logic signed [15:0]          train_feat,
   input  wire logic        [15:0]          inv_scale,
   output rkr_pkg::lane_res_type            res
);
   logic signed [16:0] diff;
   logic        [15:0] mag;
   logic        [31:0] s_full;
   logic        [17:0] s_ff;
   logic               far1_ff;
   logic        [35:0] sq;
   logic        [rkr_pkg::Q_W-1:0] q_ff;
   logic               far2_ff;

   always_comb begin
      diff   = 17'(query_feat) - 17'(train_feat);
      mag    = diff[16] ? 16'(-diff) : diff[15:0];
      s_full = 32'(mag) * 32'(inv_scale);
      sq     = 36'(s_ff) * 36'(s_ff);
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_full[17:0];
      far1_ff <= |s_full[31:18];
      q_ff    <= sq[35:16];
      far2_ff <= far1_ff;
   end

   assign res.far = far2_ff;
   assign res.q   = q_ff;
endmodule
`default_nettype wire

/* rtl/rkr_merge.sv */
// ---------------------------------------------------------------------------
// rkr_merge
// sums the lanes, looks up the kernel, weights it and accumulates
// ---------------------------------------------------------------------------
`default_nettype none
module rkr_merge #(
   parameter int DIMS            = 4,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 in_valid,
   input  wire rkr_pkg::lane_res_type lanes [DIMS],
   input  wire logic signed [23:0]   weight,
   input  wire logic        [15:0]   signal_var,
   output rkr_pkg::merge_stat_type   stat
);
   localparam int          TW    = $clog2(EXP_TABLE_DEPTH);
   localparam logic [63:0] X_ARG = (64'd8 << 32) / EXP_TABLE_DEPTH;

   logic [16:0] exp_tab [EXP_TABLE_DEPTH];

   for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
      assign exp_tab[g] = 17'(rkr_pkg::exp_entry(g, X_ARG));
   end

   logic [21:0]        d2;
   logic               far_any;
   logic [33:0]        idx_wide;
   logic               v3_ff, v4_ff, v5_ff, v6_ff;
   logic [TW-1:0]      idx_ff;
   logic               zero_ff;
   logic signed [23:0] w3_ff, w4_ff, w5_ff;
   logic [16:0]        kern_ff;
   logic [32:0]        cov_full;
   logic [24:0]        cov_ff;
   logic signed [49:0] prod_ff;
   logic [63:0]        acc_ff;

   always_comb begin
      d2      = '0;
      far_any = 1'b0;
      for (int d = 0; d < DIMS; d++) begin
         d2      = d2 + 22'(lanes[d].q);
         far_any = far_any | lanes[d].far;
      end
      idx_wide = (34'(d2) * 34'(EXP_TABLE_DEPTH)) >> 20;
      cov_full = 33'(signal_var) * 33'(kern_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      idx_ff  <= TW'(idx_wide);
      zero_ff <= far_any | (|d2[21:20]);
      w3_ff   <= weight;
      kern_ff <= zero_ff ? 17'd0 : exp_tab[idx_ff];
      w4_ff   <= w3_ff;
      cov_ff  <= cov_full[32:8];
      w5_ff   <= w4_ff;
      prod_ff <= $signed({1'b0, cov_ff}) * 50'(w5_ff);
      if (start) acc_ff <= '0;
      else if (v6_ff) acc_ff <= acc_ff + 64'(prod_ff);
   end

   assign stat.busy = v3_ff | v4_ff | v5_ff | v6_ff;
   assign stat.acc  = acc_ff;
endmodule
`default_nettype wire

/* rtl/rbf_kernel_regression_predict.sv */
// ---------------------------------------------------------------------------
// rbf_kernel_regression_predict
// gaussian-process mean prediction with a squared-exponential kernel
//
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata index, features, weight; tuser op
// rsp_      out  rsp_tvalid/rsp_tready  tdata prediction; tuser saturated
// csr_      in   csr_valid/csr_ready    csr_index, csr_data
//
// a query reads n stored points, n being train_count capped at MAX_TRAIN, or
// none with an empty store; one stored point is read per cycle with all
// dimensions in parallel lanes
// reset is synchronous and clears the control and setting registers to their defaults
// the result waits in an output register; a new request is taken meanwhile
// and a finished query holds until that register is free
// ---------------------------------------------------------------------------
`default_nettype none
`include "rbf_kernel_regression_predict_defines.svh"
module rbf_kernel_regression_predict #(
   parameter int MAX_TRAIN       = 256,
   parameter int DIMS            = 4,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // entry_index, feature_0, feature_1, feature_2, feature_3, weight
   input  wire logic [95:0] req_tdata,
   // operation
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // prediction
   output logic [31:0]      rsp_tdata,
   // saturated
   output logic             rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int AW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
   localparam int CW = $clog2(MAX_TRAIN + 1);
   localparam int RW = DIMS * rkr_pkg::FEAT_W + rkr_pkg::WEIGHT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [15:0]        inv_scale_ff [4];
   logic [15:0]        signal_var_ff;
   logic [31:0]        mean_offset_ff;
   logic [8:0]         train_count_ff;

   logic [1:0]         state_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      n_ff;
   logic signed [15:0] x_ff [4];
   logic               rd_vld_ff, lv1_ff, lv2_ff;
   logic signed [23:0] wd1_ff, wd2_ff;
   logic               rsp_tvalid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_sat_ff;

   logic               req_fire, load_fire, query_fire, issue, out_load;
   logic [RW-1:0]      wr_data, rd_data;
   logic [CW-1:0]      n_in;
   logic signed [63:0] q_val, total;
   rkr_pkg::lane_res_type   lane_res [DIMS];
   rkr_pkg::merge_stat_type mstat;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign load_fire  = req_fire & (req_tuser == rkr_pkg::OP_LOAD)
                       & (13'(req_tdata[7:0]) < 13'(MAX_TRAIN));
   assign query_fire = req_fire & (req_tuser == rkr_pkg::OP_QUERY);
   assign issue      = (state_ff == ST_RUN) & (cnt_ff < n_ff);
   assign out_load   = (state_ff == ST_FIN) & (~rsp_tvalid_ff | rsp_tready);

   always_comb begin
      wr_data = '0;
      for (int d = 0; d < DIMS; d++) begin
         wr_data[d*16 +: 16] = req_tdata[8 + d*16 +: 16];
      end
      wr_data[DIMS*16 +: 24] = req_tdata[95:72];
      n_in  = (13'(train_count_ff) > 13'(MAX_TRAIN)) ? CW'(MAX_TRAIN)
                                                      : CW'(train_count_ff);
      q_val = $signed(mstat.acc) >>> 16;
      total = q_val + 64'($signed(mean_offset_ff));
   end

   rkr_ram #(.WIDTH(RW), .DEPTH(MAX_TRAIN)) u_store (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (AW'(req_tdata[7:0])),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   for (genvar d = 0; d < DIMS; d++) begin : g_lane
      rkr_lane u_lane (
         .clock      (clock),
         .query_feat (x_ff[d]),
         .train_feat ($signed(rd_data[d*16 +: 16])),
         .inv_scale  (inv_scale_ff[d]),
         .res        (lane_res[d])
      );
   end

   rkr_merge #(.DIMS(DIMS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .start      (query_fire),
      .in_valid   (lv2_ff),
      .lanes      (lane_res),
      .weight     (wd2_ff),
      .signal_var (signal_var_ff),
      .stat       (mstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < 4; d++) inv_scale_ff[d] <= 16'd256;
         signal_var_ff  <= 16'd256;
         mean_offset_ff <= '0;
         train_count_ff <= '0;
      end else if (csr_valid & csr_ready) begin
         unique case (csr_index) inside
            rkr_pkg::CSR_INV_SCALE_0, rkr_pkg::CSR_INV_SCALE_1,
            rkr_pkg::CSR_INV_SCALE_2, rkr_pkg::CSR_INV_SCALE_3: begin
               inv_scale_ff[csr_index[1:0]] <= csr_data[15:0];
            end
            rkr_pkg::CSR_SIGNAL_VAR:  signal_var_ff  <= csr_data[15:0];
            rkr_pkg::CSR_MEAN_OFFSET: mean_offset_ff <= csr_data;
            rkr_pkg::CSR_TRAIN_COUNT: train_count_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         n_ff          <= '0;
         rd_vld_ff     <= 1'b0;
         lv1_ff        <= 1'b0;
         lv2_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         lv1_ff    <= rd_vld_ff;
         lv2_ff    <= lv1_ff;
         if (out_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (query_fire) begin
                  state_ff <= ST_RUN;
                  cnt_ff   <= '0;
                  n_ff     <= n_in;
               end
            end
            ST_RUN: begin
               if (issue) cnt_ff <= cnt_ff + 1'b1;
               else if (~rd_vld_ff & ~lv1_ff & ~lv2_ff & ~mstat.busy) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (query_fire) begin
         for (int d = 0; d < 4; d++) x_ff[d] <= $signed(req_tdata[8 + d*16 +: 16]);
      end
      wd1_ff <= $signed(rd_data[DIMS*16 +: 24]);
      wd2_ff <= wd1_ff;
      if (out_load) begin
         if (total > 64'sh7FFFFFFF) begin
            rsp_data_ff <= 32'h7FFFFFFF;
            rsp_sat_ff  <= 1'b1;
         end else if (total < -64'sh80000000) begin
            rsp_data_ff <= 32'h80000000;
            rsp_sat_ff  <= 1'b1;
         end else begin
            rsp_data_ff <= total[31:0];
            rsp_sat_ff  <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   `RKR_ASSERT_SAME(a_rsp_from_fin, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == ST_FIN)
   `RKR_ASSERT_NEXT(a_query_runs, clock, reset, query_fire, state_ff == ST_RUN)
   `RKR_ASSERT_SAME(a_cnt_bound, clock, reset, state_ff == ST_RUN, cnt_ff <= n_ff)
   `RKR_ASSERT_SAME(a_fin_drained, clock, reset, state_ff == ST_FIN, !rd_vld_ff && !lv1_ff && !lv2_ff && !mstat.busy)
endmodule
`default_nettype wire

/* tb/sv/rbf_kernel_regression_predict_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbf_kernel_regression_predict_tb
// self-checking bench for the gaussian-process mean predictor
//
// loads training points, programs the kernel registers and sends queries
// under bursty requests and a stalling response side; a bit-exact model in
// the bench predicts every prediction and saturation flag
// ----------------------------------------------------------------------------
module rbf_kernel_regression_predict_tb;

   localparam int STORE_DEPTH = 256;
   localparam int LUT_DEPTH   = 256;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [31:0] prediction;
      logic        saturated;
   } mean_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // model state
   logic [31:0]        exp_lut [LUT_DEPTH];
   logic signed [15:0] pt_feat [STORE_DEPTH][4];
   logic signed [23:0] pt_wt [STORE_DEPTH];
   bit                 pt_loaded [STORE_DEPTH];
   logic [15:0]        scale_reg [4];
   logic [15:0]        var_reg;
   logic signed [31:0] offset_reg;
   logic [8:0]         count_reg;

   mean_result_type pending_means [$];
   int fail_count = 0;
   int cycle_count = 0;
   int query_count = 0;
   int load_count = 0;
   int burst_left = 0;
   int stall_mode = 0;

   rbf_kernel_regression_predict i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void build_exp_lut();
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      logic [63:0] ratio;
      logic [63:0] arg;
      logic [63:0] acc;
      term = 64'd1 << 32;
      plus = term;
      minus = 0;
      arg = (64'd8 << 32) / LUT_DEPTH;
      for (int n = 1; n <= 15; n++) begin
         term = ((term * arg) >> 32) / n;
         if (n % 2) minus += term;
         else plus += term;
      end
      ratio = plus - minus;
      acc = 64'd1 << 32;
      for (int k = 0; k < LUT_DEPTH; k++) begin
         exp_lut[k] = 32'((acc + 64'h8000) >> 16);
         acc = (acc * ratio) >> 32;
      end
   endfunction

   function automatic logic [31:0] kernel_value(logic signed [15:0] x [4], int slot);
      logic [63:0] sq_sum;
      logic [63:0] mag;
      logic [63:0] sd;
      longint      diff;
      sq_sum = 0;
      for (int d = 0; d < 4; d++) begin
         diff = longint'(x[d]) - longint'(pt_feat[slot][d]);
         mag = (diff < 0) ? -diff : diff;
         sd = mag * scale_reg[d];
         if (sd >= (64'd4 << 16)) return 0;
         sq_sum += (sd * sd) >> 16;
      end
      if (sq_sum >= (64'd1 << 20)) return 0;
      return exp_lut[(sq_sum * LUT_DEPTH) >> 20];
   endfunction

   function automatic mean_result_type predict_mean(logic signed [15:0] x [4]);
      mean_result_type res;
      longint       acc;
      longint       cov;
      longint       total;
      int           n;
      acc = 0;
      n = (count_reg > STORE_DEPTH) ? STORE_DEPTH : count_reg;
      for (int i = 0; i < n; i++) begin
         cov = longint'((64'(var_reg) * kernel_value(x, i)) >> 8);
         acc += cov * longint'(pt_wt[i]);
      end
      total = (acc >>> 16) + longint'(offset_reg);
      res.saturated = 1'b0;
      if (total > 64'sd2147483647) begin
         total = 64'sd2147483647;
         res.saturated = 1'b1;
      end else if (total < -64'sd2147483648) begin
         total = -64'sd2147483648;
         res.saturated = 1'b1;
      end
      res.prediction = total[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count % 16) < 11;
      endcase
   end

   always @(posedge clock) begin
      mean_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            $error("unexpected response: prediction %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_tdata !== want.prediction) begin
               $error("prediction: expected %h actual %h", want.prediction, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== want.saturated) begin
               $error("saturated: expected %b actual %b", want.saturated, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   task automatic send_request(logic op, logic [7:0] slot, logic signed [15:0] x [4],
                               logic signed [23:0] wt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {wt, x[3], x[2], x[1], x[0], slot};
      do @(posedge clock); while (!req_tready);
      if (op == rkr_pkg::OP_LOAD) begin
         pt_feat[slot] = x;
         pt_wt[slot] = wt;
         pt_loaded[slot] = 1'b1;
         load_count++;
      end else begin
         pending_means.push_back(predict_mean(x));
         query_count++;
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx) inside
         rkr_pkg::CSR_INV_SCALE_0, rkr_pkg::CSR_INV_SCALE_1,
         rkr_pkg::CSR_INV_SCALE_2, rkr_pkg::CSR_INV_SCALE_3:
            scale_reg[idx] = value[15:0];
         rkr_pkg::CSR_SIGNAL_VAR: var_reg = value[15:0];
         rkr_pkg::CSR_MEAN_OFFSET: offset_reg = value;
         rkr_pkg::CSR_TRAIN_COUNT: count_reg = value[8:0];
         default: ;
      endcase
   endtask

   task automatic set_all_csr(logic [15:0] sc [4], logic [15:0] sv, logic [31:0] mo,
                              logic [8:0] cnt);
      wait_idle();
      write_csr(rkr_pkg::CSR_INV_SCALE_0, sc[0]);
      write_csr(rkr_pkg::CSR_INV_SCALE_1, sc[1]);
      write_csr(rkr_pkg::CSR_INV_SCALE_2, sc[2]);
      write_csr(rkr_pkg::CSR_INV_SCALE_3, sc[3]);
      write_csr(rkr_pkg::CSR_SIGNAL_VAR, sv);
      write_csr(rkr_pkg::CSR_MEAN_OFFSET, mo);
      write_csr(rkr_pkg::CSR_TRAIN_COUNT, cnt);
      csr_valid <= 1'b0;
   endtask

   task automatic send_query(logic signed [15:0] x [4]);
      send_request(rkr_pkg::OP_QUERY, 8'($urandom), x, 24'($urandom));
   endtask

   task automatic test_empty_store();
      logic signed [15:0] x [4];
      logic [15:0]        sc [4];
      sc = '{16'd256, 16'd256, 16'd256, 16'd256};
      x = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0100};
      send_query(x);
      set_all_csr(sc, 16'd256, 32'h8000_0000, 9'd0);
      send_query(x);
   endtask

   task automatic test_extremes();
      logic signed [15:0] x [4];
      logic [15:0]        sc [4];
      logic signed [15:0] ext [4];
      ext = '{-16'sh8000, 16'sh7fff, 16'sh0000, -16'sh0001};
      for (int i = 0; i < 8; i++) begin
         x = '{ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]};
         send_request(rkr_pkg::OP_LOAD, 8'(i), x, (i % 2) ? 24'sh7fffff : -24'sh800000);
      end
      sc = '{16'd0, 16'd0, 16'd0, 16'd0};
      set_all_csr(sc, 16'hffff, 32'h7fff_ffff, 9'd8);
      x = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      send_query(x);
      send_request(rkr_pkg::OP_LOAD, 8'd1, x, -24'sh800000);
      send_query(x);
      set_all_csr(sc, 16'hffff, 32'h8000_0000, 9'd8);
      send_query(x);
      sc = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
      set_all_csr(sc, 16'd256, 32'h0001_0000, 9'd8);
      x = ext;
      send_query(x);
      sc = '{16'd256, 16'd1, 16'd128, 16'd512};
      set_all_csr(sc, 16'h8000, 32'h0000_0000, 9'd8);
      send_query(x);
      x = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
      send_query(x);
   endtask

   task automatic test_full_store();
      logic signed [15:0] x [4];
      logic [15:0]        sc [4];
      for (int i = 0; i < STORE_DEPTH; i++) begin
         foreach (x[d]) x[d] = 16'($urandom_range(0, 2047)) - 16'sd1024;
         send_request(rkr_pkg::OP_LOAD, 8'(i), x, 24'($urandom));
      end
      sc = '{16'd128, 16'd128, 16'd128, 16'd128};
      set_all_csr(sc, 16'd256, 32'($urandom), 9'd256);
      x = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      send_query(x);
      // count above the store depth
      set_all_csr(sc, 16'd1000, 32'($urandom), 9'd511);
      send_query(x);
      set_all_csr(sc, 16'd300, 32'h0, 9'd300);
      send_query(x);
   endtask

   task automatic test_random_settings();
      logic signed [15:0] x [4];
      logic [15:0]        sc [4];
      logic [8:0]         cnt;
      logic [31:0]        mo;
      int                 pick;
      for (int phase = 0; phase < 10; phase++) begin
         foreach (sc[d]) begin
            case ($urandom_range(0, 5))
               0: sc[d] = 16'd0;
               1: sc[d] = 16'hffff;
               2: sc[d] = 16'($urandom);
               default: sc[d] = 16'($urandom_range(1, 1024));
            endcase
         end
         cnt = ($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(0, 24));
         mo = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 32'h40000))
              - 32'h20000;
         set_all_csr(sc, ($urandom_range(0, 4) == 0) ? 16'hffff : 16'($urandom), mo, cnt);
         for (int k = 0; k < 30; k++) begin
            if ($urandom_range(0, 2) == 0) begin
               foreach (x[d]) x[d] = 16'($urandom);
               send_request(rkr_pkg::OP_LOAD, 8'($urandom), x, 24'($urandom));
            end else begin
               pick = (cnt == 0) ? 0 : $urandom_range(0, (cnt > STORE_DEPTH ? STORE_DEPTH : cnt) - 1);
               foreach (x[d]) begin
                  if ($urandom_range(0, 4) == 0) x[d] = 16'($urandom);
                  else x[d] = pt_feat[pick][d] + 16'($urandom_range(0, 1023)) - 16'sd512;
               end
               send_query(x);
            end
         end
      end
   endtask

   initial begin
      build_exp_lut();
      scale_reg = '{16'd256, 16'd256, 16'd256, 16'd256};
      var_reg = 16'd256;
      offset_reg = 32'sd0;
      count_reg = 9'd0;
      foreach (pt_loaded[i]) pt_loaded[i] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_extremes();
      test_full_store();
      test_random_settings();
      wait_idle();
      repeat (300) @(posedge clock);
      $display("covered %0d loads and %0d queries over empty, extreme, full and random settings",
               load_count, query_count);
      if (fail_count == 0 && pending_means.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
